>>> src/sliding_window_aggregate_filter_top_macros.svh
// Assertion helpers for the filter's RTL.
`ifndef SLIDING_WINDOW_AGGREGATE_FILTER_TOP_MACROS_SVH
`define SLIDING_WINDOW_AGGREGATE_FILTER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWAF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/swaf_pkg.sv
`default_nettype none
package swaf_pkg;

  typedef enum logic [1:0] {
    AGG_MEAN   = 2'd0,
    AGG_MEDIAN = 2'd1,
    AGG_MIN    = 2'd2,
    AGG_MAX    = 2'd3
  } mode_t;

  localparam logic [1:0] CFG_IDX_MODE     = 2'd0;
  localparam logic [1:0] CFG_IDX_WINDOW   = 2'd1;
  localparam logic [1:0] CFG_IDX_CHANNELS = 2'd2;
  localparam logic [1:0] CFG_IDX_NONE     = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int WIN_CFG_W  = 7;
  localparam int CH_CFG_W   = 4;
  localparam int CH_OUT_W   = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_SCAN,
    ST_MSUM,
    ST_ABS,
    ST_RND,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } alu_flags_t;

endpackage
`default_nettype wire

>>> src/sliding_window_aggregate_filter_top.sv
// Multi-channel sliding-window filter: mean, median, minimum or maximum.
// Input channel (in_valid/in_ready/in_value): one sample per transfer,
// channels in order 0..channel_count-1; each transfer yields one result on
// the output channel (out_valid/out_ready) with its channel and last flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// index 0 mode, 1 window size, 2 channel count. Any write to a known index
// restarts the window (head, fill count and channel position go to zero).
// Write config only while no sample is in flight.
// One sample is worked by a single shared add/subtract unit reading the
// window memory one entry per cycle. Min/max scan the n valid entries once,
// mean sums them, then takes the magnitude, rounds and divides bit by bit,
// and median ranks every entry against every other one. in_ready stays low
// from the input transfer until the result register is loaded.
// The result register lets the next sample in while an earlier result
// waits; a stalled receiver holds the block in its final step until the
// register frees up.
// Reset (synchronous, rst_n low) restores mode mean, window 1, one channel,
// and an empty window; window memory contents are not cleared.
`default_nettype none
`include "sliding_window_aggregate_filter_top_macros.svh"
module sliding_window_aggregate_filter_top #(
  parameter int WINDOW_MAX   = 64,
  parameter int CHANNELS_MAX = 8,
  parameter int SAMPLE_WIDTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]       in_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]            out_aggregate,
  output logic [swaf_pkg::CH_OUT_W-1:0]             out_channel,
  output logic                                      out_last_channel,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [swaf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [swaf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int W_W   = $clog2(WINDOW_MAX + 1);
  localparam int CN_W  = $clog2(CHANNELS_MAX + 1);
  localparam int CH_W  = (CHANNELS_MAX > 1) ? $clog2(CHANNELS_MAX) : 1;
  localparam int DEPTH = WINDOW_MAX * CHANNELS_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W = SW + W_W + 2;
  localparam int DV_W  = W_W + 1;
  localparam int K_W   = $clog2(ACC_W + 1);

  // configuration and window progress
  swaf_pkg::mode_t               mode_r;
  logic [swaf_pkg::WIN_CFG_W-1:0] window_size_r;
  logic [swaf_pkg::CH_CFG_W-1:0]  channel_count_r;
  logic [W_W-1:0]                head_r;
  logic [W_W-1:0]                valid_count_r;
  logic [CH_W-1:0]               ch_pos_r;

  logic [W_W-1:0]  w_eff;
  logic [CN_W-1:0] nch_eff;
  logic            last_calc;
  logic [W_W-1:0]  n_calc;
  logic [AW-1:0]   base_calc;
  logic [AW-1:0]   wr_addr;

  // sequencer state
  swaf_pkg::state_t state_r, state_nxt;
  logic [W_W-1:0]   i_r, i_nxt;
  logic [W_W-1:0]   j_r, j_nxt;
  logic [W_W-1:0]   lt_r, lt_nxt;
  logic [W_W-1:0]   le_r, le_nxt;
  logic [SW-1:0]    cand_r, cand_nxt;
  logic [SW-1:0]    med1_r, med1_nxt;
  logic [SW-1:0]    med2_r, med2_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [DV_W-1:0]  rem_r, rem_nxt;
  logic [DV_W-1:0]  div_r, div_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic             neg_r, neg_nxt;
  logic [AW-1:0]    base_r, base_nxt;
  logic [W_W-1:0]   n_r, n_nxt;
  logic [CH_W-1:0]  och_r, och_nxt;
  logic             olast_r, olast_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [SW-1:0]                 out_agg_r, out_agg_nxt;
  logic [swaf_pkg::CH_OUT_W-1:0] out_ch_r, out_ch_nxt;
  logic                          out_last_r, out_last_nxt;

  logic in_fire;
  logic cfg_fire;
  logic cfg_known;

  // memory and shared unit
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [SW-1:0]    rd_data;
  logic [ACC_W-1:0] rd_sext;
  logic [ACC_W-1:0] cand_sext;

  logic [ACC_W-1:0]        alu_a, alu_b, alu_sum;
  swaf_pkg::alu_op_t       alu_op;
  swaf_pkg::alu_flags_t    alu_flags;

  logic [W_W-1:0] k1, k2;
  logic           qbit;

  swaf_store #(.DEPTH(DEPTH), .AW(AW), .DW(SW)) u_store (
    .clk       (clk),
    .wr_en     (in_fire),
    .wr_addr   (wr_addr),
    .wr_data   (in_value),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  swaf_alu #(.W(ACC_W)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .op    (alu_op),
    .sum   (alu_sum),
    .flags (alu_flags)
  );

  // effective window and channel count, clamped to their legal range
  always_comb begin
    if (window_size_r == '0) begin
      w_eff = W_W'(1);
    end else if (32'(window_size_r) > WINDOW_MAX) begin
      w_eff = W_W'(WINDOW_MAX);
    end else begin
      w_eff = W_W'(window_size_r);
    end
    if (channel_count_r == '0) begin
      nch_eff = CN_W'(1);
    end else if (32'(channel_count_r) > CHANNELS_MAX) begin
      nch_eff = CN_W'(CHANNELS_MAX);
    end else begin
      nch_eff = CN_W'(channel_count_r);
    end
  end

  assign last_calc = (32'(ch_pos_r) + 32'd1) >= 32'(nch_eff);
  assign n_calc    = (valid_count_r < w_eff) ? (valid_count_r + W_W'(1)) : w_eff;
  assign base_calc = AW'(32'(ch_pos_r) * 32'(w_eff));
  assign wr_addr   = base_calc + AW'(head_r);

  assign in_ready  = (state_r == swaf_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == swaf_pkg::CFG_IDX_MODE) ||
                     (cfg_index == swaf_pkg::CFG_IDX_WINDOW) ||
                     (cfg_index == swaf_pkg::CFG_IDX_CHANNELS);

  assign rd_sext   = {{(ACC_W-SW){rd_data[SW-1]}}, rd_data};
  assign cand_sext = {{(ACC_W-SW){cand_r[SW-1]}}, cand_r};
  assign k1        = (n_r - W_W'(1)) >> 1;
  assign k2        = n_r >> 1;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lt_nxt        = lt_r;
    le_nxt        = le_r;
    cand_nxt      = cand_r;
    med1_nxt      = med1_r;
    med2_nxt      = med2_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    k_nxt         = k_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    n_nxt         = n_r;
    och_nxt       = och_r;
    olast_nxt     = olast_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_agg_nxt   = out_agg_r;
    out_ch_nxt    = out_ch_r;
    out_last_nxt  = out_last_r;
    alu_a         = acc_r;
    alu_b         = rd_sext;
    alu_op        = swaf_pkg::ALU_ADD;
    rd_en         = 1'b0;
    rd_addr       = base_r + AW'(j_r);
    qbit          = 1'b0;

    unique case (state_r)
      swaf_pkg::ST_IDLE: begin
        if (in_fire) begin
          base_nxt  = base_calc;
          n_nxt     = n_calc;
          och_nxt   = ch_pos_r;
          olast_nxt = last_calc;
          div_nxt   = DV_W'(n_calc);
          acc_nxt   = '0;
          i_nxt     = '0;
          j_nxt     = '0;
          if (mode_r == swaf_pkg::AGG_MEDIAN) begin
            state_nxt = swaf_pkg::ST_CAND;
          end else begin
            state_nxt = swaf_pkg::ST_SCAN;
          end
        end
      end

      swaf_pkg::ST_CAND: begin
        rd_en     = 1'b1;
        rd_addr   = base_r + AW'(i_r);
        j_nxt     = '0;
        lt_nxt    = '0;
        le_nxt    = '0;
        state_nxt = swaf_pkg::ST_SCAN;
      end

      swaf_pkg::ST_SCAN: begin
        // issue entry j, work on entry j-1 arriving from the memory
        rd_en = (j_r < n_r);
        j_nxt = j_r + W_W'(1);
        case (mode_r)
          swaf_pkg::AGG_MEAN: begin
            if (j_r != '0) begin
              acc_nxt = alu_sum;
            end
          end
          swaf_pkg::AGG_MIN: begin
            alu_a  = rd_sext;
            alu_b  = acc_r;
            alu_op = swaf_pkg::ALU_SUB;
            if ((j_r == W_W'(1)) || ((j_r != '0) && alu_flags.neg)) begin
              acc_nxt = rd_sext;
            end
          end
          swaf_pkg::AGG_MAX: begin
            alu_a  = acc_r;
            alu_b  = rd_sext;
            alu_op = swaf_pkg::ALU_SUB;
            if ((j_r == W_W'(1)) || ((j_r != '0) && alu_flags.neg)) begin
              acc_nxt = rd_sext;
            end
          end
          default: begin
            alu_a  = rd_sext;
            alu_b  = cand_sext;
            alu_op = swaf_pkg::ALU_SUB;
            if (j_r == '0) begin
              cand_nxt = rd_data;
            end else begin
              lt_nxt = lt_r + W_W'(alu_flags.neg);
              le_nxt = le_r + W_W'(alu_flags.neg || alu_flags.zero);
            end
          end
        endcase

        if (j_r == n_r) begin
          case (mode_r) inside
            swaf_pkg::AGG_MEAN: begin
              state_nxt = swaf_pkg::ST_ABS;
            end
            swaf_pkg::AGG_MIN, swaf_pkg::AGG_MAX: begin
              neg_nxt   = 1'b0;
              state_nxt = swaf_pkg::ST_FIN;
            end
            default: begin
              // candidate sits at the ranks covered by [lt, le)
              if ((lt_nxt <= k1) && (k1 < le_nxt)) begin
                med1_nxt = cand_r;
              end
              if ((lt_nxt <= k2) && (k2 < le_nxt)) begin
                med2_nxt = cand_r;
              end
              if ((i_r + W_W'(1)) < n_r) begin
                i_nxt     = i_r + W_W'(1);
                state_nxt = swaf_pkg::ST_CAND;
              end else if (n_r[0]) begin
                acc_nxt   = {{(ACC_W-SW){med1_nxt[SW-1]}}, med1_nxt};
                neg_nxt   = 1'b0;
                state_nxt = swaf_pkg::ST_FIN;
              end else begin
                state_nxt = swaf_pkg::ST_MSUM;
              end
            end
          endcase
        end
      end

      swaf_pkg::ST_MSUM: begin
        alu_a     = {{(ACC_W-SW){med1_r[SW-1]}}, med1_r};
        alu_b     = {{(ACC_W-SW){med2_r[SW-1]}}, med2_r};
        acc_nxt   = alu_sum;
        div_nxt   = DV_W'(2);
        state_nxt = swaf_pkg::ST_ABS;
      end

      swaf_pkg::ST_ABS: begin
        alu_a   = '0;
        alu_b   = acc_r;
        alu_op  = swaf_pkg::ALU_SUB;
        neg_nxt = acc_r[ACC_W-1];
        if (acc_r[ACC_W-1]) begin
          acc_nxt = alu_sum;
        end
        state_nxt = swaf_pkg::ST_RND;
      end

      swaf_pkg::ST_RND: begin
        // add half the divisor so truncation rounds to nearest
        alu_a     = acc_r;
        alu_b     = ACC_W'(div_r >> 1);
        acc_nxt   = alu_sum;
        rem_nxt   = '0;
        k_nxt     = '0;
        state_nxt = swaf_pkg::ST_DIV;
      end

      swaf_pkg::ST_DIV: begin
        alu_a  = ACC_W'({rem_r, acc_r[ACC_W-1]});
        alu_b  = ACC_W'(div_r);
        alu_op = swaf_pkg::ALU_SUB;
        if (!alu_flags.neg) begin
          qbit    = 1'b1;
          rem_nxt = alu_sum[DV_W-1:0];
        end else begin
          rem_nxt = {rem_r[DV_W-2:0], acc_r[ACC_W-1]};
        end
        acc_nxt = {acc_r[ACC_W-2:0], qbit};
        k_nxt   = k_r + K_W'(1);
        if (k_r == K_W'(ACC_W - 1)) begin
          state_nxt = swaf_pkg::ST_FIN;
        end
      end

      swaf_pkg::ST_FIN: begin
        alu_a  = '0;
        alu_b  = acc_r;
        alu_op = swaf_pkg::ALU_SUB;
        // hold here until the result register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_agg_nxt   = neg_r ? alu_sum[SW-1:0] : acc_r[SW-1:0];
          out_ch_nxt    = swaf_pkg::CH_OUT_W'(och_r);
          out_last_nxt  = olast_r;
          state_nxt     = swaf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = swaf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swaf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= swaf_pkg::AGG_MEAN;
      window_size_r   <= swaf_pkg::WIN_CFG_W'(1);
      channel_count_r <= swaf_pkg::CH_CFG_W'(1);
      head_r          <= '0;
      valid_count_r   <= '0;
      ch_pos_r        <= '0;
    end else if (cfg_fire && cfg_known) begin
      unique case (cfg_index)
        swaf_pkg::CFG_IDX_MODE:   mode_r <= swaf_pkg::mode_t'(cfg_data[1:0]);
        swaf_pkg::CFG_IDX_WINDOW: window_size_r <= cfg_data[swaf_pkg::WIN_CFG_W-1:0];
        default:                  channel_count_r <= cfg_data[swaf_pkg::CH_CFG_W-1:0];
      endcase
      head_r        <= '0;
      valid_count_r <= '0;
      ch_pos_r      <= '0;
    end else if (in_fire) begin
      // advance the shared head once the last channel of a vector is in
      if (last_calc) begin
        head_r        <= ((head_r + W_W'(1)) == w_eff) ? '0 : (head_r + W_W'(1));
        valid_count_r <= n_calc;
        ch_pos_r      <= '0;
      end else begin
        ch_pos_r <= ch_pos_r + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    lt_r       <= lt_nxt;
    le_r       <= le_nxt;
    cand_r     <= cand_nxt;
    med1_r     <= med1_nxt;
    med2_r     <= med2_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    k_r        <= k_nxt;
    neg_r      <= neg_nxt;
    base_r     <= base_nxt;
    n_r        <= n_nxt;
    och_r      <= och_nxt;
    olast_r    <= olast_nxt;
    out_agg_r  <= out_agg_nxt;
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_aggregate    = out_agg_r;
  assign out_channel      = out_ch_r;
  assign out_last_channel = out_last_r;

  `SWAF_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready after input transfer")
  `SWAF_ASSERT_IMPL(a_div_rem, state_r == swaf_pkg::ST_DIV, rem_r < div_r, "remainder not below divisor")
  `SWAF_ASSERT_IMPL(a_window_fill, 1'b1, (valid_count_r <= w_eff) && (head_r < w_eff), "window progress out of range")

endmodule
`default_nettype wire

>>> src/swaf_alu.sv
`default_nettype none
module swaf_alu #(
  parameter int W = 40
) (
  input  wire logic [W-1:0]        a,
  input  wire logic [W-1:0]        b,
  input  wire swaf_pkg::alu_op_t   op,
  output logic [W-1:0]             sum,
  output swaf_pkg::alu_flags_t     flags
);

  always_comb begin
    case (op)
      swaf_pkg::ALU_SUB: sum = a - b;
      default:           sum = a + b;
    endcase
    flags.neg  = sum[W-1];
    flags.zero = (sum == '0);
  end

endmodule
`default_nettype wire

>>> src/swaf_store.sv
`default_nettype none
module swaf_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data_r
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;

  localparam int WIN_LIMIT = 64;
  localparam int CH_LIMIT  = 8;
  localparam int DEPTH     = WIN_LIMIT * CH_LIMIT;

  typedef struct {
    logic signed [31:0] aggregate;
    logic [2:0]         channel;
    logic               last_channel;
  } filter_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_value;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_aggregate;
  logic [2:0] out_channel;
  logic out_last_channel;
  logic cfg_valid;
  logic cfg_ready;
  logic [swaf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [swaf_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [1:0] mode_reg;
  logic [6:0] window_reg;
  logic [3:0] channels_reg;
  logic signed [31:0] window_mem [DEPTH];
  int head_pos;
  int fill_count;
  int chan_pos;

  filter_result_t pending_results[$];
  int mismatches;
  int rx_hold;
  bit tx_jitter;
  bit rx_jitter;

  sliding_window_aggregate_filter_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_aggregate(out_aggregate),
    .out_channel(out_channel), .out_last_channel(out_last_channel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint round_half_away(longint s, longint c);
    longint mag;
    longint q;
    mag = (s < 0) ? -s : s;
    q = (mag + c / 2) / c;
    return (s < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] window_aggregate(int base, int n);
    longint acc;
    longint best;
    longint v;
    longint srt[WIN_LIMIT];
    int i;
    int j;
    acc = 0;
    best = window_mem[base];
    case (swaf_pkg::mode_t'(mode_reg))
      swaf_pkg::AGG_MEAN: begin
        for (i = 0; i < n; i++) acc += window_mem[base + i];
        return 32'(round_half_away(acc, n));
      end
      swaf_pkg::AGG_MEDIAN: begin
        for (i = 0; i < n; i++) begin
          v = window_mem[base + i];
          j = i;
          while (j > 0 && srt[j - 1] > v) begin
            srt[j] = srt[j - 1];
            j--;
          end
          srt[j] = v;
        end
        if (n % 2 == 1) return 32'(srt[n / 2]);
        return 32'(round_half_away(srt[n / 2 - 1] + srt[n / 2], 2));
      end
      swaf_pkg::AGG_MIN: begin
        for (i = 1; i < n; i++) if (window_mem[base + i] < best) best = window_mem[base + i];
        return 32'(best);
      end
      default: begin
        for (i = 1; i < n; i++) if (window_mem[base + i] > best) best = window_mem[base + i];
        return 32'(best);
      end
    endcase
  endfunction

  task automatic predict_sample(input logic signed [31:0] v);
    int w;
    int nch;
    int ch;
    int n;
    int base;
    filter_result_t r;
    w = (window_reg < 1) ? 1 : (window_reg > WIN_LIMIT) ? WIN_LIMIT : window_reg;
    nch = (channels_reg < 1) ? 1 : (channels_reg > CH_LIMIT) ? CH_LIMIT : channels_reg;
    ch = chan_pos;
    if (ch >= nch) ch = nch - 1;
    if (head_pos >= w) head_pos = 0;
    if (fill_count > w) fill_count = w;
    base = ch * w;
    window_mem[(base + head_pos) % DEPTH] = v;
    n = (fill_count < w) ? fill_count + 1 : w;
    r.aggregate = window_aggregate(base, n);
    r.channel = ch[2:0];
    r.last_channel = (ch + 1 >= nch);
    if (r.last_channel) begin
      head_pos = (head_pos + 1) % w;
      fill_count = n;
      chan_pos = 0;
    end else begin
      chan_pos = ch + 1;
    end
    pending_results.push_back(r);
  endtask

  task automatic send_sample(input logic signed [31:0] v);
    int gap;
    gap = (tx_jitter && $urandom_range(99) < 20) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(v);
  endtask

  // wait for every outstanding result before touching registers
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [swaf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swaf_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      swaf_pkg::CFG_IDX_MODE:     mode_reg = d[1:0];
      swaf_pkg::CFG_IDX_WINDOW:   window_reg = d;
      swaf_pkg::CFG_IDX_CHANNELS: channels_reg = d[3:0];
      default:                    return;
    endcase
    head_pos = 0;
    fill_count = 0;
    chan_pos = 0;
  endtask

  task automatic configure(input swaf_pkg::mode_t m, input int w, input int nch);
    write_reg(swaf_pkg::CFG_IDX_MODE, 7'(m));
    write_reg(swaf_pkg::CFG_IDX_WINDOW, 7'(w));
    write_reg(swaf_pkg::CFG_IDX_CHANNELS, 7'(nch));
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(3))
      0: return $signed(32'($urandom_range(16))) - 8;
      1: case ($urandom_range(3))
        0: return 32'sh7FFFFFFF;
        1: return 32'sh80000000;
        2: return -1;
        default: return 0;
      endcase
      default: return $urandom;
    endcase
  endfunction

  task automatic test_mean_extremes;
    drain();
    configure(swaf_pkg::AGG_MEAN, 2, 1);
    send_sample(32'sh7FFFFFFF);
    send_sample(32'sh7FFFFFFF);
    send_sample(32'sh80000000);
    send_sample(32'sh80000000);
    send_sample(1);
    send_sample(2);
    send_sample(-1);
    send_sample(-2);
  endtask

  task automatic test_median_even;
    drain();
    configure(swaf_pkg::AGG_MEDIAN, 4, 1);
    send_sample(5);
    send_sample(-4);
    send_sample(8);
    send_sample(-3);
    send_sample(32'sh7FFFFFFF);
  endtask

  task automatic test_min_max_channels;
    drain();
    configure(swaf_pkg::AGG_MIN, 3, 3);
    repeat (6) send_sample(pick_sample());
    drain();
    // mode data carries stray high bits; only the low two count
    write_reg(swaf_pkg::CFG_IDX_MODE, 7'h7F);
    repeat (6) send_sample(pick_sample());
  endtask

  task automatic test_out_of_range_regs;
    drain();
    configure(swaf_pkg::AGG_MAX, 0, 0);
    repeat (3) send_sample(pick_sample());
    drain();
    configure(swaf_pkg::AGG_MEAN, 127, 15);
    repeat (10) send_sample(pick_sample());
    drain();
    // unknown index leaves the window running
    write_reg(swaf_pkg::CFG_IDX_NONE, 7'h55);
    repeat (6) send_sample(pick_sample());
  endtask

  task automatic test_receiver_stall;
    drain();
    configure(swaf_pkg::AGG_MIN, 2, 2);
    rx_hold = 400;
    repeat (8) send_sample(pick_sample());
  endtask

  task automatic test_median_full_window;
    drain();
    configure(swaf_pkg::AGG_MEDIAN, 64, 1);
    repeat (70) send_sample(pick_sample());
  endtask

  task automatic test_random_phases;
    int p;
    int w;
    swaf_pkg::mode_t m;
    for (p = 0; p < 60; p++) begin
      tx_jitter = (p >= 3);
      rx_jitter = (p >= 3);
      drain();
      m = swaf_pkg::mode_t'($urandom_range(3));
      case ($urandom_range(9))
        0: w = $urandom_range(9, 24);
        1: w = (m == swaf_pkg::AGG_MEDIAN) ? $urandom_range(9, 16) : 64;
        default: w = $urandom_range(1, 8);
      endcase
      configure(m, w, $urandom_range(1, 8));
      if ($urandom_range(4) == 0) write_reg(swaf_pkg::CFG_IDX_NONE, 7'($urandom));
      repeat ($urandom_range(20, 40)) send_sample(pick_sample());
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    mode_reg = 2'd0;
    window_reg = 7'd1;
    channels_reg = 4'd1;
    head_pos = 0;
    fill_count = 0;
    chan_pos = 0;
    mismatches = 0;
    rx_hold = 0;
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_mean_extremes();
    test_median_even();
    test_min_max_channels();
    test_out_of_range_regs();
    test_receiver_stall();
    test_median_full_window();
    test_random_phases();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= !rx_jitter || ($urandom_range(99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    filter_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: agg %0d ch %0d last %0d",
                                       out_aggregate, out_channel, out_last_channel);
      end else begin
        e = pending_results.pop_front();
        if (out_aggregate !== e.aggregate || out_channel !== e.channel ||
            out_last_channel !== e.last_channel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp agg %0d ch %0d last %0d, got agg %0d ch %0d last %0d",
                     e.aggregate, e.channel, e.last_channel,
                     out_aggregate, out_channel, out_last_channel);
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/swaf_pkg.sv
src/swaf_alu.sv
src/swaf_store.sv
src/sliding_window_aggregate_filter_top.sv
tb/testbench.sv
